// ----- src/bsui_pkg.sv -----
// Shared types and constants for the bounded set union / intersection core.
// Used by bsui_cell, bsui_out and bounded_set_union_intersection_core.
// No dependencies.
package bsui_pkg;

  // maximum members per set
  localparam int unsigned SetCap = 32;
  // width of a count that can hold SetCap itself
  localparam int unsigned CntW   = $clog2(SetCap + 1);
  localparam int unsigned ValW   = 32;

  // command codes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_UNION = 3'd2;
  localparam logic [2:0] OP_INTER = 3'd3;
  localparam logic [2:0] OP_EQUAL = 3'd4;

  // add status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic            rot_a;
    logic            rot_b;
    logic [ValW-1:0] key;
  } cell_ctrl_t;

  // one result item
  typedef struct packed {
    logic [ValW-1:0] value;
    logic            has_value;
    logic [1:0]      status;
    logic            equal;
    logic            last;
  } out_item_t;

endpackage

// ----- src/bounded_set_union_intersection_core.sv -----
// Top level of the bounded set union / intersection core: sequencer, cell row
// and output register. Depends on bsui_pkg, bsui_cell and bsui_out.
//
// Usage:
// Commands arrive on the in channel (opcode, set_select, element) with a
// valid/ready transfer; results leave on the out channel, one item per
// transfer, the final item of each command marked by last_o.
// Clear, add and unused codes are taken when the output register is free,
// and their single item is presented on the next cycle.
// Union, intersection and equality run over the cell row: it rotates one
// slot per cycle unless held by a stalled output, so each stored member
// passes the head, where it is matched against the other set in parallel.
// A pass always rotates by SetCap slots, so the row returns to its original
// order; intersection and equality pass over A, union over A and then B.
// One command is in work at a time; in_ready_o is low until its last item
// has been placed in the output register.
// When the receiver stalls, the row simply holds its position and nothing
// is lost. Reset empties both sets (counts to zero) and the output register;
// stored members need no clearing.
module bounded_set_union_intersection_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       opcode_i,
  input  logic                             set_select_i,
  input  logic signed [bsui_pkg::ValW-1:0] element_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [bsui_pkg::ValW-1:0] value_out_o,
  output logic                             has_value_o,
  output logic [1:0]                       add_status_o,
  output logic                             equal_flag_o,
  output logic                             last_o
);
  import bsui_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PASS_A = 2'd1;
  localparam logic [1:0] S_PASS_B = 2'd2;
  localparam logic [1:0] S_FLUSH  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [2:0]      op_q, op_d;
  logic [CntW-1:0] cnt_a_q, cnt_a_d;
  logic [CntW-1:0] cnt_b_q, cnt_b_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] n_q, n_d;
  logic            pend_v_q, pend_v_d;
  logic [ValW-1:0] pend_q, pend_d;
  logic            eq_q, eq_d;

  cell_ctrl_t      ctrl;
  logic            wr_a_en, wr_b_en;
  logic            push;
  out_item_t       push_item;
  out_item_t       item;
  logic            out_free;
  logic            in_fire;

  logic [SetCap-1:0] hit_a_vec, hit_b_vec;
  logic [ValW-1:0]   a_vec [SetCap];
  logic [ValW-1:0]   b_vec [SetCap];
  logic              hit_a_any, hit_b_any;
  logic              in_set, emit, adv;

  // cell row, each cell fed from its upper neighbour, cell 0 is the head
  for (genvar k = 0; k < SetCap; k++) begin : g_cell
    localparam int unsigned Nxt = (k + 1) % SetCap;
    bsui_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .wr_a_i  (wr_a_en && (cnt_a_q == CntW'(k))),
      .wr_b_i  (wr_b_en && (cnt_b_q == CntW'(k))),
      .vld_a_i (CntW'(k) < cnt_a_q),
      .vld_b_i (CntW'(k) < cnt_b_q),
      .nxt_a_i (a_vec[Nxt]),
      .nxt_b_i (b_vec[Nxt]),
      .a_o     (a_vec[k]),
      .b_o     (b_vec[k]),
      .hit_a_o (hit_a_vec[k]),
      .hit_b_o (hit_b_vec[k])
    );
  end

  assign hit_a_any = |hit_a_vec;
  assign hit_b_any = |hit_b_vec;

  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // command sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    step_d     = step_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    eq_d       = eq_q;
    ctrl.rot_a = 1'b0;
    ctrl.rot_b = 1'b0;
    ctrl.key   = element_i;
    wr_a_en    = 1'b0;
    wr_b_en    = 1'b0;
    push       = 1'b0;
    push_item  = '0;
    in_set     = 1'b0;
    emit       = 1'b0;
    adv        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d = opcode_i;
          case (opcode_i)
            OP_CLEAR: begin
              push           = 1'b1;
              push_item.last = 1'b1;
              if (set_select_i) begin
                cnt_b_d = '0;
              end else begin
                cnt_a_d = '0;
              end
            end
            OP_ADD: begin
              push           = 1'b1;
              push_item.last = 1'b1;
              if (set_select_i) begin
                if (cnt_b_q >= CntW'(SetCap)) begin
                  push_item.status = ST_FULL;
                end else if (hit_b_any) begin
                  push_item.status = ST_DUP;
                end else begin
                  push_item.status = ST_ADDED;
                  wr_b_en          = 1'b1;
                  cnt_b_d          = cnt_b_q + CntW'(1);
                end
              end else begin
                if (cnt_a_q >= CntW'(SetCap)) begin
                  push_item.status = ST_FULL;
                end else if (hit_a_any) begin
                  push_item.status = ST_DUP;
                end else begin
                  push_item.status = ST_ADDED;
                  wr_a_en          = 1'b1;
                  cnt_a_d          = cnt_a_q + CntW'(1);
                end
              end
            end
            OP_UNION, OP_INTER, OP_EQUAL: begin
              state_d  = S_PASS_A;
              step_d   = '0;
              n_d      = '0;
              pend_v_d = 1'b0;
              eq_d     = (cnt_a_q == cnt_b_q);
            end
            default: begin
              push           = 1'b1;
              push_item.last = 1'b1;
            end
          endcase
        end
      end

      // set A passes the head, matched against stationary set B
      S_PASS_A: begin
        ctrl.key = a_vec[0];
        in_set   = step_q < cnt_a_q;
        case (op_q)
          OP_UNION: emit = in_set && (n_q < CntW'(SetCap));
          OP_INTER: emit = in_set && hit_b_any && (n_q < CntW'(SetCap));
          default:  emit = 1'b0;
        endcase
        adv = !(emit && pend_v_q) || out_free;
        if (emit && pend_v_q && out_free) begin
          push            = 1'b1;
          push_item.value = pend_q;
          push_item.has_value = 1'b1;
        end
        if (adv) begin
          ctrl.rot_a = 1'b1;
          step_d     = step_q + CntW'(1);
          if ((op_q == OP_EQUAL) && in_set && !hit_b_any) begin
            eq_d = 1'b0;
          end
          if (emit) begin
            pend_v_d = 1'b1;
            pend_d   = a_vec[0];
            n_d      = n_q + CntW'(1);
          end
          if (step_q == CntW'(SetCap - 1)) begin
            step_d  = '0;
            state_d = (op_q == OP_UNION) ? S_PASS_B : S_FLUSH;
          end
        end
      end

      // set B passes the head, matched against stationary set A
      S_PASS_B: begin
        ctrl.key = b_vec[0];
        in_set   = step_q < cnt_b_q;
        emit     = in_set && !hit_a_any && (n_q < CntW'(SetCap));
        adv      = !(emit && pend_v_q) || out_free;
        if (emit && pend_v_q && out_free) begin
          push            = 1'b1;
          push_item.value = pend_q;
          push_item.has_value = 1'b1;
        end
        if (adv) begin
          ctrl.rot_b = 1'b1;
          step_d     = step_q + CntW'(1);
          if (emit) begin
            pend_v_d = 1'b1;
            pend_d   = b_vec[0];
            n_d      = n_q + CntW'(1);
          end
          if (step_q == CntW'(SetCap - 1)) begin
            step_d  = '0;
            state_d = S_FLUSH;
          end
        end
      end

      // final item of a scanning command
      S_FLUSH: begin
        if (out_free) begin
          push           = 1'b1;
          push_item.last = 1'b1;
          if (op_q == OP_EQUAL) begin
            push_item.equal = eq_q;
          end else if (pend_v_q) begin
            push_item.value     = pend_q;
            push_item.has_value = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_CLEAR;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      step_q   <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      eq_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      step_q   <= step_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      eq_q     <= eq_d;
    end
  end

  // held member waiting to learn whether it is the last one
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // output register
  bsui_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (item)
  );

  assign value_out_o  = $signed(item.value);
  assign has_value_o  = item.has_value;
  assign add_status_o = item.status;
  assign equal_flag_o = item.equal;
  assign last_o       = item.last;

  // set counts never pass capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CntW'(SetCap)) && (cnt_b_q <= CntW'(SetCap)))
    else $error("set count above capacity");

  // streamed item count never passes capacity
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (n_q <= CntW'(SetCap)))
    else $error("union output above capacity");

  // a held member only exists while a scan is running
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("held member left over in idle");

  // a successful add to set A grows its count by one
  a_add_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (opcode_i == OP_ADD) && !set_select_i &&
     (cnt_a_q < CntW'(SetCap)) && !hit_a_any)
    |=> (cnt_a_q == $past(cnt_a_q) + CntW'(1)))
    else $error("add to set A did not grow the count");

endmodule

// ----- src/bsui_cell.sv -----
// One slot of the cell row: holds entry k of set A and entry k of set B.
// Rotates towards cell k-1 on request and matches both entries against a key.
// Depends on bsui_pkg.
module bsui_cell (
  input  logic                      clk_i,
  input  bsui_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      wr_a_i,
  input  logic                      wr_b_i,
  input  logic                      vld_a_i,
  input  logic                      vld_b_i,
  input  logic [bsui_pkg::ValW-1:0] nxt_a_i,
  input  logic [bsui_pkg::ValW-1:0] nxt_b_i,
  output logic [bsui_pkg::ValW-1:0] a_o,
  output logic [bsui_pkg::ValW-1:0] b_o,
  output logic                      hit_a_o,
  output logic                      hit_b_o
);
  import bsui_pkg::*;

  logic [ValW-1:0] a_q;
  logic [ValW-1:0] b_q;

  // entry of set A: written on add, shifted from the neighbour on rotation
  always_ff @(posedge clk_i) begin
    if (wr_a_i) begin
      a_q <= ctrl_i.key;
    end else if (ctrl_i.rot_a) begin
      a_q <= nxt_a_i;
    end
  end

  // entry of set B
  always_ff @(posedge clk_i) begin
    if (wr_b_i) begin
      b_q <= ctrl_i.key;
    end else if (ctrl_i.rot_b) begin
      b_q <= nxt_b_i;
    end
  end

  // match against the broadcast key, only for occupied slots
  assign hit_a_o = vld_a_i && (a_q == ctrl_i.key);
  assign hit_b_o = vld_b_i && (b_q == ctrl_i.key);

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

// ----- src/bsui_out.sv -----
// Output register of the core: holds one result item until its transfer.
// Depends on bsui_pkg.
module bsui_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bsui_pkg::out_item_t item_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bsui_pkg::out_item_t item_o
);
  import bsui_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for bounded_set_union_intersection_core: random and
// directed set commands, each reply predicted in the bench and checked per field.
// Depends on bsui_pkg and the core RTL.
module testbench;
  import bsui_pkg::*;

  // command codes that the core does not use
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int ClkHalf    = 4;
  localparam int MaxGap     = 12;
  localparam int LongStall  = 300;
  localparam int RandomCmds = 60;
  localparam int RunLimit   = 8 * 600000;

  typedef struct {
    logic [2:0]  op;
    logic        sel;
    logic [31:0] elem;
    bit          drain;
  } set_cmd_t;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [2:0]             opcode_i     = '0;
  logic                   set_select_i = 1'b0;
  logic signed [ValW-1:0] element_i    = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic signed [ValW-1:0] value_out_o;
  logic                   has_value_o;
  logic [1:0]             add_status_o;
  logic                   equal_flag_o;
  logic                   last_o;

  // pending commands and predicted replies
  set_cmd_t  cmd_q[$];
  out_item_t reply_q[$];

  // bench copy of both sets
  logic [31:0] mem_a [SetCap];
  logic [31:0] mem_b [SetCap];
  int cnt_a = 0;
  int cnt_b = 0;

  int err_cnt     = 0;
  int n_planned   = 0;
  int n_predicted = 0;
  int n_results   = 0;
  int n_cmds      = 0;
  int n_union     = 0;
  int n_inter     = 0;
  int n_equal     = 0;
  int n_full      = 0;
  int n_dup       = 0;
  int n_capped    = 0;

  int tx_wait     = 0;
  int rx_wait     = 0;
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  int stall_left  = 0;
  int stalls_done = 0;
  int stall_at    = 40;

  bounded_set_union_intersection_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .set_select_i (set_select_i),
    .element_i    (element_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_out_o  (value_out_o),
    .has_value_o  (has_value_o),
    .add_status_o (add_status_o),
    .equal_flag_o (equal_flag_o),
    .last_o       (last_o)
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  task automatic report(input string what);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  // gap before the next transfer, with quiet stretches of no idling
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic bit holds(input bit in_b, input logic [31:0] v);
    int n;
    n = in_b ? cnt_b : cnt_a;
    for (int i = 0; i < n; i++) begin
      if ((in_b ? mem_b[i] : mem_a[i]) == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // work out the reply items of one accepted command and update the sets
  task automatic predict_reply(input logic [2:0] op, input logic sel,
                               input logic [31:0] elem);
    out_item_t row[$];
    out_item_t it;
    out_item_t m;
    int n;
    it = '0;
    m = '0;
    m.has_value = 1'b1;
    case (op)
      OP_CLEAR: begin
        if (sel) cnt_b = 0;
        else cnt_a = 0;
      end
      OP_ADD: begin
        n = sel ? cnt_b : cnt_a;
        if (n >= SetCap) begin
          it.status = ST_FULL;
          n_full++;
        end else if (holds(sel, elem)) begin
          it.status = ST_DUP;
          n_dup++;
        end else if (sel) begin
          mem_b[cnt_b] = elem;
          cnt_b++;
        end else begin
          mem_a[cnt_a] = elem;
          cnt_a++;
        end
      end
      OP_UNION: begin
        n_union++;
        for (int i = 0; i < cnt_a; i++) begin
          m.value = mem_a[i];
          row.push_back(m);
        end
        for (int i = 0; i < cnt_b; i++) begin
          if (!holds(1'b0, mem_b[i])) begin
            if (row.size() < SetCap) begin
              m.value = mem_b[i];
              row.push_back(m);
            end else begin
              n_capped++;
            end
          end
        end
      end
      OP_INTER: begin
        n_inter++;
        for (int i = 0; i < cnt_a; i++) begin
          if (holds(1'b1, mem_a[i])) begin
            m.value = mem_a[i];
            row.push_back(m);
          end
        end
      end
      OP_EQUAL: begin
        n_equal++;
        it.equal = (cnt_a == cnt_b);
        for (int i = 0; i < cnt_a; i++) begin
          if (!holds(1'b1, mem_a[i])) it.equal = 1'b0;
        end
      end
      default: ;
    endcase
    if (row.size() == 0) row.push_back(it);
    row[$].last = 1'b1;
    foreach (row[i]) reply_q.push_back(row[i]);
    n_predicted += row.size();
  endtask

  task automatic check_reply();
    out_item_t exp;
    if (reply_q.size() == 0) begin
      report($sformatf("result with nothing pending: value %0d has %0b last %0b",
                       value_out_o, has_value_o, last_o));
      return;
    end
    exp = reply_q.pop_front();
    if (value_out_o !== exp.value)
      report($sformatf("value_out %0d, expected %0d", value_out_o, $signed(exp.value)));
    if (has_value_o !== exp.has_value)
      report($sformatf("has_value %0b, expected %0b", has_value_o, exp.has_value));
    if (add_status_o !== exp.status)
      report($sformatf("add_status %0d, expected %0d", add_status_o, exp.status));
    if (equal_flag_o !== exp.equal)
      report($sformatf("equal_flag %0b, expected %0b", equal_flag_o, exp.equal));
    if (last_o !== exp.last)
      report($sformatf("last %0b, expected %0b", last_o, exp.last));
  endtask

  // stimulus helpers
  task automatic push_cmd(input logic [2:0] op, input logic sel,
                          input logic [31:0] elem, input bit drain);
    set_cmd_t c;
    c.op    = op;
    c.sel   = sel;
    c.elem  = elem;
    c.drain = drain;
    cmd_q.push_back(c);
    if (op <= OP_EQUAL) n_planned++;
  endtask

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // mostly a small pool, so sets overlap and duplicates turn up
  function automatic logic [31:0] pick_member();
    int s;
    s = $urandom_range(0, 9);
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return edge_value();
      default: return s - 4;
    endcase
  endfunction

  function automatic logic [2:0] pick_query();
    case ($urandom_range(0, 2))
      0:       return OP_UNION;
      1:       return OP_INTER;
      default: return OP_EQUAL;
    endcase
  endfunction

  initial begin : stimulus_gen
    logic [31:0] vals [SetCap];
    int base;
    int kind;
    int n;
    int k;

    // directed: empty sets, field extremes, duplicates, spare codes, clears
    push_cmd(OP_EQUAL, 1'b0, '0, 1'b0);
    push_cmd(OP_UNION, 1'b1, '0, 1'b0);
    push_cmd(OP_INTER, 1'b0, '1, 1'b0);
    push_cmd(OP_ADD, 1'b0, 32'h8000_0000, 1'b0);
    push_cmd(OP_ADD, 1'b0, 32'h7fff_ffff, 1'b0);
    push_cmd(OP_ADD, 1'b0, 32'h0000_0000, 1'b0);
    push_cmd(OP_ADD, 1'b0, 32'hffff_ffff, 1'b0);
    push_cmd(OP_ADD, 1'b0, 32'hffff_ffff, 1'b0);
    push_cmd(OP_ADD, 1'b1, 32'h7fff_ffff, 1'b0);
    push_cmd(OP_ADD, 1'b1, 32'h0000_0005, 1'b0);
    push_cmd(OP_ADD, 1'b1, 32'h8000_0000, 1'b0);
    push_cmd(OP_UNION, 1'b0, 32'h5555_aaaa, 1'b0);
    push_cmd(OP_INTER, 1'b1, '0, 1'b0);
    push_cmd(OP_EQUAL, 1'b0, '0, 1'b0);
    push_cmd(OP_RSVD5, 1'b1, 32'hffff_ffff, 1'b0);
    push_cmd(OP_RSVD6, 1'b0, 32'h7fff_ffff, 1'b0);
    push_cmd(OP_RSVD7, 1'b1, 32'h8000_0000, 1'b0);
    push_cmd(OP_UNION, 1'b0, '0, 1'b0);
    push_cmd(OP_CLEAR, 1'b0, 32'h1234_5678, 1'b0);
    push_cmd(OP_EQUAL, 1'b0, '0, 1'b0);
    push_cmd(OP_CLEAR, 1'b1, '1, 1'b0);
    push_cmd(OP_EQUAL, 1'b1, '0, 1'b0);
    push_cmd(OP_UNION, 1'b0, '0, 1'b0);
    push_cmd(OP_INTER, 1'b0, '0, 1'b0);

    // both sets to capacity, then adds to full sets and a capped union
    push_cmd(OP_CLEAR, 1'b0, '0, 1'b1);
    push_cmd(OP_CLEAR, 1'b1, '0, 1'b0);
    for (int i = 0; i < SetCap; i++) begin
      vals[i] = (i << 20) ^ $urandom_range(0, 32'hf_ffff);
      push_cmd(OP_ADD, 1'b0, vals[i], 1'b0);
    end
    for (int i = 0; i < SetCap; i++) begin
      if ($urandom_range(0, 1)) push_cmd(OP_ADD, 1'b1, vals[i], 1'b0);
      else push_cmd(OP_ADD, 1'b1, ((i << 20) ^ $urandom_range(0, 32'hf_ffff))
                    | 32'h8000_0000, 1'b0);
    end
    push_cmd(OP_ADD, 1'b0, 32'h7fff_fff0, 1'b0);
    push_cmd(OP_ADD, 1'b0, vals[3], 1'b0);
    push_cmd(OP_ADD, 1'b1, 32'h8000_0001, 1'b0);
    push_cmd(OP_UNION, 1'b0, '0, 1'b0);
    push_cmd(OP_INTER, 1'b0, '0, 1'b0);
    push_cmd(OP_EQUAL, 1'b0, '0, 1'b0);
    // few members in A, so the union hits capacity part way through B
    push_cmd(OP_CLEAR, 1'b0, '0, 1'b0);
    for (int i = 0; i < 5; i++) push_cmd(OP_ADD, 1'b0, $urandom, 1'b0);
    push_cmd(OP_UNION, 1'b1, '0, 1'b0);
    push_cmd(OP_INTER, 1'b1, '0, 1'b0);

    base = n_planned;

    // random well-formed sequences with some noise
    while (n_planned - base < RandomCmds) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          if (kind < 4) begin
            push_cmd(OP_CLEAR, 1'b0, $urandom, $urandom_range(0, 3) == 0);
            push_cmd(OP_CLEAR, 1'b1, $urandom, 1'b0);
          end
          n = $urandom_range(0, 10);
          for (int i = 0; i < n; i++)
            push_cmd(OP_ADD, 1'($urandom_range(0, 1)), pick_member(), 1'b0);
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            push_cmd(pick_query(), 1'($urandom_range(0, 1)), $urandom, 1'b0);
        end
        6: begin
          // same members, opposite order
          push_cmd(OP_CLEAR, 1'b0, $urandom, $urandom_range(0, 3) == 0);
          push_cmd(OP_CLEAR, 1'b1, $urandom, 1'b0);
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            vals[i] = pick_member();
            push_cmd(OP_ADD, 1'b0, vals[i], 1'b0);
          end
          for (int i = n - 1; i >= 0; i--) push_cmd(OP_ADD, 1'b1, vals[i], 1'b0);
          push_cmd(OP_EQUAL, 1'($urandom_range(0, 1)), $urandom, 1'b0);
          push_cmd(pick_query(), 1'($urandom_range(0, 1)), $urandom, 1'b0);
        end
        7, 8: begin
          for (int i = 0; i < 6; i++)
            push_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom,
                     1'b0);
        end
        default: begin
          k = $urandom_range(0, 1);
          push_cmd(OP_CLEAR, 1'(k), $urandom, 1'b0);
          push_cmd(pick_query(), 1'($urandom_range(0, 1)), $urandom, 1'b0);
          push_cmd(OP_ADD, 1'(k), pick_member(), 1'b0);
          push_cmd(pick_query(), 1'($urandom_range(0, 1)), $urandom, 1'b0);
        end
      endcase
    end
  end

  // command driver: one transfer per item, random gaps, optional drain first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      opcode_i     <= '0;
      set_select_i <= 1'b0;
      element_i    <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_reply(opcode_i, set_select_i, element_i);
        n_cmds++;
        tx_wait = draw_gap(tx_quiet);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the offered item until the transfer
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() != 0 &&
                   (!cmd_q[0].drain || n_results == n_predicted)) begin
        opcode_i     <= cmd_q[0].op;
        set_select_i <= cmd_q[0].sel;
        element_i    <= cmd_q[0].elem;
        in_valid_i   <= 1'b1;
        void'(cmd_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the core fills up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left  <= 0;
      stalls_done <= 0;
      stall_at    <= 40;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_done < 2 && n_results >= stall_at) begin
      stall_left  <= LongStall;
      stalls_done <= stalls_done + 1;
      stall_at    <= stall_at + 150;
    end
  end

  // result monitor: check each transfer, then draw the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_reply();
        n_results <= n_results + 1;
        rx_wait = draw_gap(rx_quiet);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0) && (stall_left == 0);
    end
  end

  initial begin : watchdog
    #(RunLimit);
    $display("[bounded_set_union_intersection_core] ERROR");
    $finish;
  end

  // reset, wait for every reply, let the core settle, then report
  initial begin : run_ctrl
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || n_results != n_predicted)
      @(posedge clk_i);
    repeat (2 * SetCap + 8) @(posedge clk_i);
    $display("ran %0d commands giving %0d result items: %0d unions (%0d members cut at capacity),",
             n_cmds, n_results, n_union, n_capped);
    $display("%0d intersections, %0d equality tests, %0d adds to a full set, %0d duplicate adds",
             n_inter, n_equal, n_full, n_dup);
    if (err_cnt == 0) begin
      $display("[bounded_set_union_intersection_core] OK");
    end else begin
      $display("[bounded_set_union_intersection_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bsui_pkg.sv
src/bsui_cell.sv
src/bsui_out.sv
src/bounded_set_union_intersection_core.sv
test/testbench.sv
